// ===== hdl/i2c_bit_level_master_core_defines.svh =====
// ----------------------------------------------------------------------------
// I2C bit-level master core: assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef I2C_BIT_LEVEL_MASTER_CORE_DEFINES_SVH
`define I2C_BIT_LEVEL_MASTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define I2CBM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define I2CBM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define I2CBM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define I2CBM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/i2cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C bit-level master package
// Item types, operation codes and the single-segment sequencer step.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbm_pkg;

  localparam logic       KIND_CMD  = 1'b0;
  localparam logic       KIND_TICK = 1'b1;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_WACK  = 3'd4;
  localparam logic [2:0] OP_ACK   = 3'd5;
  localparam logic [2:0] OP_NACK  = 3'd6;
  localparam logic [2:0] OP_PROBE = 3'd7;

  localparam logic [7:0] HALF_PERIOD_RST = 8'd10;
  localparam logic [2:0] LAST_BIT        = 3'd7;
  // probe sub-sequences sit in phase groups of four: start, write, wait ack, stop
  localparam logic [1:0] GRP_START = 2'd0;
  localparam logic [1:0] GRP_WRITE = 2'd1;
  localparam logic [1:0] GRP_WACK  = 2'd2;
  localparam logic [1:0] GRP_STOP  = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       no_ack;
    logic       rejected;
  } out_item_t;

  typedef enum logic [1:0] {
    SEG_DELAY = 2'd0,
    SEG_NEXT  = 2'd1,
    SEG_END   = 2'd2
  } seg_code_t;

  typedef struct packed {
    logic [3:0] phase;
    logic [2:0] bit_cnt;
    logic [7:0] shift_out;
    logic [7:0] shift_in;
    logic       scl;
    logic       sda;
    logic       ack;
  } seq_st_t;

  typedef struct packed {
    seq_st_t   st;
    seg_code_t code;
  } seg_res_t;

  // Run one segment of the sequence selected by op and st.phase.
  function automatic seg_res_t seg_run(logic [2:0] op, seq_st_t st, logic sda_in);
    seg_res_t   r;
    logic [1:0] p;
    logic [1:0] grp;
    logic [2:0] sub;
    r      = '{st: st, code: SEG_DELAY};
    p      = st.phase[1:0];
    grp    = 2'd0;
    sub    = op;
    if (op == OP_PROBE) begin
      grp = st.phase[3:2];
      unique case (grp)
        GRP_START: sub = OP_START;
        GRP_WRITE: sub = OP_WRITE;
        GRP_WACK:  sub = OP_WACK;
        default:   sub = OP_STOP;
      endcase
    end
    unique case (sub)
      OP_START: begin
        unique case (p)
          2'd0: begin r.st.sda = 1'b1; r.st.scl = 1'b1; p = 2'd1; end
          2'd1: begin r.st.sda = 1'b0; p = 2'd2; end
          2'd2: begin r.st.scl = 1'b0; p = 2'd3; end
          default: r.code = SEG_END;
        endcase
      end
      OP_STOP: begin
        if (p == 2'd0) begin
          r.st.sda = 1'b0;
          r.st.scl = 1'b1;
          p        = 2'd1;
        end else begin
          r.st.sda = 1'b1;
          r.code   = SEG_END;
        end
      end
      OP_WRITE: begin
        unique case (p)
          2'd0: begin r.st.sda = st.shift_out[7]; p = 2'd1; end
          2'd1: begin r.st.scl = 1'b1; p = 2'd2; end
          2'd2: begin
            r.st.scl = 1'b0;
            // release SDA for the ack slot after the last bit
            if (st.bit_cnt == LAST_BIT) r.st.sda = 1'b1;
            r.st.shift_out = {st.shift_out[6:0], 1'b0};
            p = 2'd3;
          end
          default: begin
            if (st.bit_cnt == LAST_BIT) begin
              r.code = SEG_END;
            end else begin
              r.st.bit_cnt = st.bit_cnt + 3'd1;
              p            = 2'd0;
              r.code       = SEG_NEXT;
            end
          end
        endcase
      end
      OP_READ: begin
        unique case (p)
          2'd0: begin r.st.scl = 1'b1; p = 2'd1; end
          2'd1: begin
            r.st.shift_in = {st.shift_in[6:0], sda_in};
            r.st.scl      = 1'b0;
            p             = 2'd2;
          end
          default: begin
            if (st.bit_cnt == LAST_BIT) begin
              r.code = SEG_END;
            end else begin
              r.st.bit_cnt = st.bit_cnt + 3'd1;
              p            = 2'd0;
              r.code       = SEG_NEXT;
            end
          end
        endcase
      end
      OP_WACK: begin
        unique case (p)
          2'd0: begin r.st.sda = 1'b1; p = 2'd1; end
          2'd1: begin r.st.scl = 1'b1; p = 2'd2; end
          2'd2: begin r.st.ack = sda_in; r.st.scl = 1'b0; p = 2'd3; end
          default: r.code = SEG_END;
        endcase
      end
      OP_ACK: begin
        unique case (p)
          2'd0: begin r.st.sda = 1'b0; p = 2'd1; end
          2'd1: begin r.st.scl = 1'b1; p = 2'd2; end
          2'd2: begin r.st.scl = 1'b0; p = 2'd3; end
          default: begin r.st.sda = 1'b1; r.code = SEG_END; end
        endcase
      end
      default: begin
        unique case (p)
          2'd0: begin r.st.sda = 1'b1; p = 2'd1; end
          2'd1: begin r.st.scl = 1'b1; p = 2'd2; end
          2'd2: begin r.st.scl = 1'b0; p = 2'd3; end
          default: r.code = SEG_END;
        endcase
      end
    endcase
    r.st.phase = {grp, p};
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/i2cbm_seq.sv =====
// ----------------------------------------------------------------------------
// I2C bit-level master sequencer
// Holds the bus state and advances it on each command and on each tick that ends a wait.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_bit_level_master_core_defines.svh"

module i2cbm_seq (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  acc,
  input  i2cbm_pkg::in_item_t  item,
  input  wire [7:0]            half_period,
  output i2cbm_pkg::out_item_t res
);

  logic [2:0]         cur_op_r, cur_op_nxt;
  logic               busy_r, busy_nxt;
  logic [7:0]         wait_r, wait_nxt;
  i2cbm_pkg::seq_st_t st_r, st_nxt;

  logic               is_cmd;
  logic               run;
  logic               rej;
  logic               done;
  logic [2:0]         op_sel;
  i2cbm_pkg::seq_st_t st0, st1;
  i2cbm_pkg::seg_res_t r1, r2;
  logic               probe_more;
  logic               second;

  assign is_cmd = (item.kind == i2cbm_pkg::KIND_CMD);
  assign rej    = acc && is_cmd && busy_r;
  assign run    = acc && ((is_cmd && !busy_r) ||
                          (!is_cmd && busy_r && (wait_r <= 8'd1)));
  assign op_sel = is_cmd ? item.op : cur_op_r;

  always_comb begin
    st0 = st_r;
    if (is_cmd) begin
      st0.phase     = '0;
      st0.bit_cnt   = '0;
      st0.shift_out = item.tx_byte;
      if (item.op == i2cbm_pkg::OP_READ) st0.shift_in = '0;
    end
  end

  assign r1 = i2cbm_pkg::seg_run(op_sel, st0, item.sda_in);

  // a finished probe sub-sequence chains straight into the next one
  assign probe_more = (r1.code == i2cbm_pkg::SEG_END) && (op_sel == i2cbm_pkg::OP_PROBE) &&
                      (r1.st.phase[3:2] != i2cbm_pkg::GRP_STOP);
  assign second     = (r1.code == i2cbm_pkg::SEG_NEXT) || probe_more;

  always_comb begin
    st1 = r1.st;
    if (probe_more) begin
      st1.phase   = {r1.st.phase[3:2] + 2'd1, 2'b00};
      st1.bit_cnt = '0;
    end
  end

  assign r2 = i2cbm_pkg::seg_run(op_sel, st1, item.sda_in);

  always_comb begin
    cur_op_nxt = cur_op_r;
    busy_nxt   = busy_r;
    wait_nxt   = wait_r;
    st_nxt     = st_r;
    done       = 1'b0;
    if (acc && !is_cmd && busy_r && (wait_r > 8'd1)) begin
      wait_nxt = wait_r - 8'd1;
    end
    if (run) begin
      cur_op_nxt = op_sel;
      if ((r1.code == i2cbm_pkg::SEG_END) && !second) begin
        busy_nxt       = 1'b0;
        wait_nxt       = '0;
        st_nxt         = r1.st;
        st_nxt.phase   = '0;
        st_nxt.bit_cnt = '0;
        done           = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        wait_nxt = half_period;
        st_nxt   = second ? r2.st : r1.st;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_op_r <= i2cbm_pkg::OP_START;
      busy_r   <= 1'b0;
      wait_r   <= '0;
      st_r     <= '{phase: '0, bit_cnt: '0, shift_out: '0, shift_in: '0,
                    scl: 1'b1, sda: 1'b1, ack: 1'b0};
    end else if (acc) begin
      cur_op_r <= cur_op_nxt;
      busy_r   <= busy_nxt;
      wait_r   <= wait_nxt;
      st_r     <= st_nxt;
    end
  end

  always_comb begin
    res.scl_out  = st_nxt.scl;
    res.sda_out  = st_nxt.sda;
    res.busy_res = busy_nxt;
    res.done_res = done;
    res.rx_byte  = st_nxt.shift_in;
    res.no_ack   = st_nxt.ack;
    res.rejected = rej;
  end

  `I2CBM_ASSERT_IMP(a_idle_clean, clk, rst_n, !busy_r, (st_r.phase == 4'd0) && (st_r.bit_cnt == 3'd0) && (wait_r == 8'd0))
  `I2CBM_ASSERT_NXT(a_reject_holds, clk, rst_n, rej, busy_r && $stable(st_r) && $stable(wait_r))
  `I2CBM_ASSERT_NXT(a_hold_without_request, clk, rst_n, !acc, $stable(st_r) && $stable(wait_r) && $stable(busy_r))

endmodule

`default_nettype wire

// ===== hdl/i2cbm_out_reg.sv =====
// ----------------------------------------------------------------------------
// I2C bit-level master result register
// Holds one result until the receiver takes it; refills in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_out_reg (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  load,
  input  i2cbm_pkg::out_item_t res,
  output logic                 can_load,
  output logic                 out_valid,
  input  wire                  out_ready,
  output i2cbm_pkg::out_item_t out_item
);

  logic                 valid_r, valid_nxt;
  i2cbm_pkg::out_item_t item_r;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load)           valid_nxt = 1'b1;
    else if (out_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

`default_nettype wire

// ===== hdl/i2c_bit_level_master_core.sv =====
// ----------------------------------------------------------------------------
// I2C bit-level master core
// Open-drain master bit engine driven by command and tick requests.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per handshake; a command starts an operation, a tick
//           carries the sampled SDA level and advances it.
//   out_* : exactly one result per request, in order, with SCL/SDA drive
//           levels, busy, done, received byte, ack status and reject flag.
//   cfg_* : writes half_period_ticks; take it only while the engine is idle.
// Results are registered: a request's result shows in the cycle after it is
// taken. Throughput is one request per cycle while the receiver does not stall,
// set by the single result register behind the sequencer.
// When the receiver stalls, the result holds and in_ready drops once the
// result register is full; a new request is taken in the same cycle that the
// held result leaves. Reset releases both lines, clears the engine state and
// loads half_period_ticks with 10. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_bit_level_master_core (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  i2cbm_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  wire                  out_ready,
  output i2cbm_pkg::out_item_t out_item,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [7:0]            cfg_data
);

  logic [7:0]           half_period_r;
  logic                 acc;
  i2cbm_pkg::out_item_t res;

  assign cfg_ready = 1'b1;
  assign acc       = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= i2cbm_pkg::HALF_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      half_period_r <= cfg_data;
    end
  end

  i2cbm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .item        (in_item),
    .half_period (half_period_r),
    .res         (res)
  );

  i2cbm_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (acc),
    .res       (res),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== dv/i2c_bus_checker.sv =====
// ----------------------------------------------------------------------------
// I2C bit-level master checker
// Watches the request, result and config channels of the master core, keeps
// its own copy of the bit engine state, and compares every result it sees
// against the predicted SCL/SDA levels and status flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module i2c_bus_checker
  import i2cbm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_ready,
  input  in_item_t     in_item,
  input  logic         out_valid,
  input  logic         out_ready,
  input  out_item_t    out_item,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [7:0]   cfg_data,
  output int unsigned  err_count,
  output int unsigned  pending_count,
  output logic         engine_busy
);

  logic [7:0] hp_reg;
  logic [2:0] active_op;
  logic       busy_r;
  logic [4:0] step_idx;
  logic [2:0] bit_idx;
  logic [7:0] hold_left;
  logic [7:0] tx_shift;
  logic [7:0] rx_shift;
  logic       scl_drv;
  logic       sda_drv;
  logic       nack_seen;
  logic [1:0] seg_step;

  out_item_t  bus_expect_q[$];
  int unsigned result_idx;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: result %0d %s mismatch, got %0h expected %0h",
             $time, result_idx, what, got, want);
    err_count++;
  endtask

  task automatic check_field(input string what, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // One segment of a primitive sequence; seg_step is the position inside it.
  function automatic seg_code_t exec_segment(input logic [2:0] sub, input logic sda_smp);
    seg_code_t code;
    code = SEG_DELAY;
    case (sub)
      OP_START: begin
        case (seg_step)
          2'd0: begin sda_drv = 1'b1; scl_drv = 1'b1; seg_step = 2'd1; end
          2'd1: begin sda_drv = 1'b0; seg_step = 2'd2; end
          2'd2: begin scl_drv = 1'b0; seg_step = 2'd3; end
          default: code = SEG_END;
        endcase
      end
      OP_STOP: begin
        if (seg_step == 2'd0) begin
          sda_drv  = 1'b0;
          scl_drv  = 1'b1;
          seg_step = 2'd1;
        end else begin
          sda_drv = 1'b1;
          code    = SEG_END;
        end
      end
      OP_WRITE: begin
        case (seg_step)
          2'd0: begin sda_drv = tx_shift[7]; seg_step = 2'd1; end
          2'd1: begin scl_drv = 1'b1; seg_step = 2'd2; end
          2'd2: begin
            scl_drv = 1'b0;
            if (bit_idx == LAST_BIT) sda_drv = 1'b1;
            tx_shift = {tx_shift[6:0], 1'b0};
            seg_step = 2'd3;
          end
          default: begin
            if (bit_idx == LAST_BIT) begin
              code = SEG_END;
            end else begin
              bit_idx  = bit_idx + 3'd1;
              seg_step = 2'd0;
              code     = SEG_NEXT;
            end
          end
        endcase
      end
      OP_READ: begin
        case (seg_step)
          2'd0: begin scl_drv = 1'b1; seg_step = 2'd1; end
          2'd1: begin
            rx_shift = {rx_shift[6:0], sda_smp};
            scl_drv  = 1'b0;
            seg_step = 2'd2;
          end
          default: begin
            if (bit_idx == LAST_BIT) begin
              code = SEG_END;
            end else begin
              bit_idx  = bit_idx + 3'd1;
              seg_step = 2'd0;
              code     = SEG_NEXT;
            end
          end
        endcase
      end
      OP_WACK: begin
        case (seg_step)
          2'd0: begin sda_drv = 1'b1; seg_step = 2'd1; end
          2'd1: begin scl_drv = 1'b1; seg_step = 2'd2; end
          2'd2: begin nack_seen = sda_smp; scl_drv = 1'b0; seg_step = 2'd3; end
          default: code = SEG_END;
        endcase
      end
      OP_ACK: begin
        case (seg_step)
          2'd0: begin sda_drv = 1'b0; seg_step = 2'd1; end
          2'd1: begin scl_drv = 1'b1; seg_step = 2'd2; end
          2'd2: begin scl_drv = 1'b0; seg_step = 2'd3; end
          default: begin sda_drv = 1'b1; code = SEG_END; end
        endcase
      end
      default: begin
        case (seg_step)
          2'd0: begin sda_drv = 1'b1; seg_step = 2'd1; end
          2'd1: begin scl_drv = 1'b1; seg_step = 2'd2; end
          2'd2: begin scl_drv = 1'b0; seg_step = 2'd3; end
          default: code = SEG_END;
        endcase
      end
    endcase
    return code;
  endfunction

  // Run segments until a wait starts or the operation ends; 1 when it ended.
  function automatic logic advance_engine(input logic sda_smp);
    logic [4:0] base;
    logic [2:0] sub;
    seg_code_t  code;
    logic       running;
    logic       fin;
    running = 1'b1;
    fin     = 1'b0;
    while (running) begin
      if (active_op == OP_PROBE) begin
        base = {1'b0, step_idx[3:2], 2'b00};
        case (step_idx[3:2])
          GRP_START: sub = OP_START;
          GRP_WRITE: sub = OP_WRITE;
          GRP_WACK:  sub = OP_WACK;
          default:   sub = OP_STOP;
        endcase
      end else begin
        base = 5'd0;
        sub  = active_op;
      end
      seg_step = step_idx[1:0];
      code     = exec_segment(sub, sda_smp);
      step_idx = base + {3'b000, seg_step};
      if (code == SEG_DELAY) begin
        hold_left = hp_reg;
        running   = 1'b0;
      end else if (code == SEG_END) begin
        if (active_op == OP_PROBE && base[3:2] != GRP_STOP) begin
          // chain into the next probe group
          step_idx = base + 5'd4;
          bit_idx  = 3'd0;
        end else begin
          busy_r    = 1'b0;
          step_idx  = 5'd0;
          bit_idx   = 3'd0;
          hold_left = 8'd0;
          fin       = 1'b1;
          running   = 1'b0;
        end
      end
    end
    return fin;
  endfunction

  task automatic step_engine(input in_item_t req);
    out_item_t want;
    logic      fin;
    logic      rej;
    fin = 1'b0;
    rej = 1'b0;
    if (req.kind == KIND_CMD) begin
      if (busy_r) begin
        rej = 1'b1;
      end else begin
        active_op = req.op;
        busy_r    = 1'b1;
        step_idx  = 5'd0;
        bit_idx   = 3'd0;
        hold_left = 8'd0;
        tx_shift  = req.tx_byte;
        if (req.op == OP_READ) rx_shift = 8'd0;
        fin = advance_engine(req.sda_in);
      end
    end else if (busy_r) begin
      if (hold_left > 8'd1) hold_left = hold_left - 8'd1;
      else fin = advance_engine(req.sda_in);
    end
    want = '{scl_out: scl_drv, sda_out: sda_drv, busy_res: busy_r, done_res: fin,
             rx_byte: rx_shift, no_ack: nack_seen, rejected: rej};
    bus_expect_q.push_back(want);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      hp_reg     = HALF_PERIOD_RST;
      active_op  = OP_START;
      busy_r     = 1'b0;
      step_idx   = 5'd0;
      bit_idx    = 3'd0;
      hold_left  = 8'd0;
      tx_shift   = 8'd0;
      rx_shift   = 8'd0;
      scl_drv    = 1'b1;
      sda_drv    = 1'b1;
      nack_seen  = 1'b0;
      err_count  = 0;
      result_idx = 0;
      bus_expect_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) hp_reg = cfg_data;
      // retire the result before predicting the request taken at this edge
      if (out_valid && out_ready) begin
        if (bus_expect_q.size() == 0) begin
          report_mismatch("unexpected result", 8'd0, 8'd0);
        end else begin
          want = bus_expect_q.pop_front();
          check_field("scl_out",  8'(out_item.scl_out),  8'(want.scl_out));
          check_field("sda_out",  8'(out_item.sda_out),  8'(want.sda_out));
          check_field("busy_res", 8'(out_item.busy_res), 8'(want.busy_res));
          check_field("done_res", 8'(out_item.done_res), 8'(want.done_res));
          check_field("rx_byte",  out_item.rx_byte,      want.rx_byte);
          check_field("no_ack",   8'(out_item.no_ack),   8'(want.no_ack));
          check_field("rejected", 8'(out_item.rejected), 8'(want.rejected));
        end
        result_idx++;
      end
      if (in_valid && in_ready) step_engine(in_item);
    end
    pending_count <= bus_expect_q.size();
    engine_busy   <= busy_r;
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// I2C bit-level master testbench top
// Drives commands and ticks into the master core with random sender gaps and
// receiver stalls, walks the half period through its extremes, and reports
// the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import i2cbm_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int          SDA_RANDOM = 0;
  localparam int          SDA_LOW    = 1;
  localparam int          SDA_HIGH   = 2;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = 8'd0;

  int unsigned err_count;
  int unsigned pending_count;
  logic        engine_busy;

  int unsigned in_gap_pct      = 0;
  int unsigned out_stall_pct   = 0;
  int unsigned ops_sent        = 0;
  int unsigned idle_cycles     = 0;
  logic [7:0]  half_period_set = HALF_PERIOD_RST;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  i2c_bit_level_master_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  i2c_bus_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .err_count     (err_count),
    .pending_count (pending_count),
    .engine_busy   (engine_busy)
  );

  function automatic in_item_t make_item(input logic kind, input logic [2:0] op,
                                         input logic [7:0] tx, input logic sda);
    in_item_t req;
    req.kind    = kind;
    req.op      = op;
    req.tx_byte = tx;
    req.sda_in  = sda;
    return req;
  endfunction

  task automatic push_request(input in_item_t req);
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_item  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic push_stray_tick();
    logic [2:0] op;
    logic [7:0] tx;
    logic       sda;
    op  = 3'($urandom_range(0, 7));
    tx  = 8'($urandom);
    sda = 1'($urandom_range(0, 1));
    push_request(make_item(KIND_TICK, op, tx, sda));
  endtask

  // Hold the sender until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (4) @(posedge clk);
  endtask

  // One command followed by exactly the ticks it needs; rej_pct sprinkles
  // commands into the busy window, which must come back rejected.
  task automatic run_op(input logic [2:0] op, input logic [7:0] tx,
                        input int sda_mode, input int unsigned rej_pct);
    int unsigned waits;
    int unsigned n;
    int unsigned i;
    logic [2:0]  rop;
    logic [7:0]  rtx;
    logic        sda;
    case (op)
      OP_STOP:  waits = 1;
      OP_WRITE: waits = 24;
      OP_READ:  waits = 16;
      OP_PROBE: waits = 31;
      default:  waits = 3;
    endcase
    n   = waits * ((half_period_set == 8'd0) ? 1 : half_period_set);
    sda = 1'($urandom_range(0, 1));
    push_request(make_item(KIND_CMD, op, tx, sda));
    for (i = 0; i < n; i++) begin
      if (rej_pct != 0 && $urandom_range(0, 99) < rej_pct) begin
        rop = 3'($urandom_range(0, 7));
        rtx = 8'($urandom);
        sda = 1'($urandom_range(0, 1));
        push_request(make_item(KIND_CMD, rop, rtx, sda));
      end
      case (sda_mode)
        SDA_LOW:  sda = 1'b0;
        SDA_HIGH: sda = 1'b1;
        default:  sda = 1'($urandom_range(0, 1));
      endcase
      rop = 3'($urandom_range(0, 7));
      rtx = 8'($urandom);
      push_request(make_item(KIND_TICK, rop, rtx, sda));
    end
    ops_sent += n + 1;
  endtask

  task automatic write_half_period(input logic [7:0] value);
    drain();
    // finish any operation still in flight before touching the register
    while (engine_busy) begin
      push_stray_tick();
      drain();
    end
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    half_period_set = value;
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned first;
    logic [2:0]  op;
    logic [7:0]  tx;
    first = ops_sent;
    while (ops_sent - first < quota) begin
      if ($urandom_range(0, 99) < 6) push_stray_tick();
      op = 3'($urandom_range(0, 7));
      tx = 8'($urandom);
      run_op(op, tx, SDA_RANDOM, 4);
      // no pauses once both sides run flat out
      if ((in_gap_pct != 0 || out_stall_pct != 0) && $urandom_range(0, 99) < 3) drain();
    end
  endtask

  initial begin : result_stall
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold != 0) hold--;
      else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct)
        hold = $urandom_range(1, 18);
      out_ready <= (hold == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("i2c_bit_level_master_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    in_gap_pct    = 10;
    out_stall_pct = 10;

    // ticks with nothing running change nothing
    push_request(make_item(KIND_TICK, OP_START, 8'h00, 1'b0));
    push_request(make_item(KIND_TICK, OP_PROBE, 8'hFF, 1'b1));
    // reset half period
    run_op(OP_STOP, 8'h00, SDA_RANDOM, 0);
    write_half_period(8'd0);
    run_op(OP_START, 8'h00, SDA_LOW, 0);
    run_op(OP_WRITE, 8'hFF, SDA_HIGH, 50);
    run_op(OP_WRITE, 8'h00, SDA_LOW, 0);
    run_op(OP_WACK, 8'h5A, SDA_LOW, 0);
    run_op(OP_READ, 8'h00, SDA_HIGH, 0);
    run_op(OP_ACK, 8'hFF, SDA_RANDOM, 0);
    run_op(OP_READ, 8'hFF, SDA_LOW, 0);
    run_op(OP_NACK, 8'h00, SDA_RANDOM, 0);
    run_op(OP_STOP, 8'hA5, SDA_RANDOM, 0);
    run_op(OP_PROBE, 8'hFF, SDA_HIGH, 0);

    write_half_period(8'd1);
    random_phase(300);

    in_gap_pct    = 0;
    out_stall_pct = 15;
    write_half_period(8'd2);
    random_phase(300);

    // longest half period on a short operation only
    in_gap_pct = 8;
    write_half_period(8'd255);
    run_op(OP_STOP, 8'h00, SDA_RANDOM, 1);

    in_gap_pct    = 20;
    out_stall_pct = 0;
    write_half_period(8'd3);
    random_phase(300);

    in_gap_pct    = 10;
    out_stall_pct = 10;
    write_half_period(8'($urandom_range(1, 6)));
    random_phase(300);

    in_gap_pct    = 0;
    out_stall_pct = 0;
    write_half_period(8'd1);
    random_phase(250);

    drain();
    repeat (8) @(posedge clk);
    if (err_count == 0 && pending_count == 0) begin
      $display("i2c_bit_level_master_core verification clean");
    end else begin
      $display("i2c_bit_level_master_core verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/i2cbm_pkg.sv
hdl/i2cbm_seq.sv
hdl/i2cbm_out_reg.sv
hdl/i2c_bit_level_master_core.sv
dv/i2c_bus_checker.sv
dv/tb_top.sv
